// ===== rtl/core/spcu_pkg.sv =====
// Shared constants for the swarm particle coordinate update block.
`default_nettype none

package spcu_pkg;

    // Word formats: signed Q15.16 positions and velocities
    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 18;    // unsigned Q2.16 coefficients
    localparam int RAND_W  = 16;    // unsigned Q0.16 random fraction
    localparam int VLIM_W  = 31;    // unsigned velocity limit

    // Stream word layouts
    localparam int S_DATA_W = 3 * WORD_W + RAND_W;
    localparam int M_DATA_W = 2 * WORD_W;

    // Register file
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VLIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 3'd4;

    localparam logic [COEF_W-1:0]        RST_INERTIA = 18'd47828;
    localparam logic [COEF_W-1:0]        RST_ACCEL   = 18'd98054;
    localparam logic [VLIM_W-1:0]        RST_VLIMIT  = 31'd13107200;
    localparam logic signed [WORD_W-1:0] RST_LOWER   = -32'sd32768000;
    localparam logic signed [WORD_W-1:0] RST_UPPER   = 32'sd32768000;

    // Pipeline depth, input register through output register
    localparam int STAGES = 7;

endpackage : spcu_pkg

`default_nettype wire

// ===== rtl/core/swarm_particle_coordinate_update.sv =====
// Particle swarm coordinate update: seven-stage velocity and position pipeline.
`default_nettype none

//  channel   direction  handshake                     word contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   velocity, position, exemplar, random
//  m_axis    out        m_axis_tvalid/m_axis_tready   new velocity, new position; tuser = hit
//  cfg       in         i_cfg_valid/o_cfg_ready       register index, write data
//
//  One word per cycle sustained while the output is taken. The depth is set by
//  the three multiplies (two in stage 1, the pull product in stage 3) and the
//  round, clamp, add and bound-compare steps, each given its own register stage.
//  Reset (synchronous, active low) empties the pipe and loads the default register values.
//  Each stage holds its word while the next is full and stalled; an empty stage
//  takes a new word even while the output waits, so bubbles close up.
module swarm_particle_coordinate_update
    import spcu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: velocity_in[31:0], position_in[63:32], exemplar_coord[95:64],
    //        random_fraction[111:96]
    input  wire logic [S_DATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata: velocity_out[31:0], position_out[63:32]
    output logic [M_DATA_W-1:0]          m_axis_tdata,
    // tuser: bound_hit[0]
    output logic                         m_axis_tuser,
    // register writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [WORD_W-1:0]       i_cfg_data
);

    // derived widths
    localparam int PW_W  = COEF_W + 1 + WORD_W;   // inertia * velocity
    localparam int T1_W  = PW_W - FRAC_W;         // rounded inertia term
    localparam int PA_W  = COEF_W + RAND_W;       // accel * random
    localparam int D_W   = WORD_W + 1;            // exemplar - position
    localparam int PF_W  = COEF_W + 1 + D_W;      // factor * difference
    localparam int T2_W  = PF_W - FRAC_W;         // rounded pull term
    localparam int NV_W  = T2_W + 1;              // exact sum of both terms
    localparam int NP_W  = WORD_W + 1;            // position plus velocity

    localparam logic signed [PW_W-1:0] HALF_PW = PW_W'(1) << (FRAC_W - 1);
    localparam logic signed [PF_W-1:0] HALF_PF = PF_W'(1) << (FRAC_W - 1);
    localparam logic [PA_W-1:0]        HALF_PA = PA_W'(1) << (RAND_W - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]        r_inertia;
    logic [COEF_W-1:0]        r_accel;
    logic [VLIM_W-1:0]        r_vlimit;
    logic signed [WORD_W-1:0] r_lower;
    logic signed [WORD_W-1:0] r_upper;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia <= RST_INERTIA;
            r_accel   <= RST_ACCEL;
            r_vlimit  <= RST_VLIMIT;
            r_lower   <= RST_LOWER;
            r_upper   <= RST_UPPER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INERTIA: r_inertia <= i_cfg_data[COEF_W-1:0];
                CFG_ACCEL:   r_accel   <= i_cfg_data[COEF_W-1:0];
                CFG_VLIMIT:  r_vlimit  <= i_cfg_data[VLIM_W-1:0];
                CFG_LOWER:   r_lower   <= $signed(i_cfg_data);
                CFG_UPPER:   r_upper   <= $signed(i_cfg_data);
                default: begin
                    // unused indexes: write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and per-stage ready chain
    // w_rdy[k] says stage k may load this cycle; w_rdy[STAGES+1] is the sink.
    // ------------------------------------------------------------------
    logic [STAGES:1]   r_vld;
    logic [STAGES+1:1] w_rdy;
    logic [STAGES:1]   w_vin;

    always_comb begin
        w_rdy[STAGES+1] = m_axis_tready;
        for (int k = STAGES; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_vin[1] = s_axis_tvalid;
        for (int k = 2; k <= STAGES; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // input word fields
    logic signed [WORD_W-1:0] w_v_in;
    logic signed [WORD_W-1:0] w_p_in;
    logic signed [WORD_W-1:0] w_e_in;
    logic [RAND_W-1:0]        w_r_in;

    assign w_v_in = $signed(s_axis_tdata[WORD_W-1:0]);
    assign w_p_in = $signed(s_axis_tdata[2*WORD_W-1:WORD_W]);
    assign w_e_in = $signed(s_axis_tdata[3*WORD_W-1:2*WORD_W]);
    assign w_r_in = s_axis_tdata[3*WORD_W+RAND_W-1:3*WORD_W];

    // ------------------------------------------------------------------
    // stage 1: inertia and accel products, exemplar difference
    // ------------------------------------------------------------------
    logic signed [PW_W-1:0]   r1_prod_w, n1_prod_w;
    logic [PA_W-1:0]          r1_prod_a, n1_prod_a;
    logic signed [D_W-1:0]    r1_diff,   n1_diff;
    logic signed [WORD_W-1:0] r1_pos;

    assign n1_prod_w = $signed({1'b0, r_inertia}) * w_v_in;
    assign n1_prod_a = r_accel * w_r_in;
    assign n1_diff   = $signed({w_e_in[WORD_W-1], w_e_in})
                     - $signed({w_p_in[WORD_W-1], w_p_in});

    // ------------------------------------------------------------------
    // stage 2: round both products (half up)
    // ------------------------------------------------------------------
    logic signed [PW_W-1:0]   w_sum_w;
    logic [PA_W-1:0]          w_sum_a;
    logic signed [T1_W-1:0]   r2_term1, n2_term1;
    logic [COEF_W-1:0]        r2_factor, n2_factor;
    logic signed [D_W-1:0]    r2_diff;
    logic signed [WORD_W-1:0] r2_pos;

    assign w_sum_w   = r1_prod_w + HALF_PW;
    assign n2_term1  = $signed(w_sum_w[PW_W-1:FRAC_W]);
    assign w_sum_a   = r1_prod_a + HALF_PA;
    assign n2_factor = w_sum_a[PA_W-1:RAND_W];

    // ------------------------------------------------------------------
    // stage 3: pull product, factor * (exemplar - position)
    // ------------------------------------------------------------------
    logic signed [PF_W-1:0]   r3_prod_f, n3_prod_f;
    logic signed [T1_W-1:0]   r3_term1;
    logic signed [WORD_W-1:0] r3_pos;

    assign n3_prod_f = $signed({1'b0, r2_factor}) * r2_diff;

    // ------------------------------------------------------------------
    // stage 4: round pull term, exact sum
    // ------------------------------------------------------------------
    logic signed [PF_W-1:0]   w_sum_f;
    logic signed [T2_W-1:0]   w_term2;
    logic signed [NV_W-1:0]   r4_nv, n4_nv;
    logic signed [WORD_W-1:0] r4_pos;

    assign w_sum_f = r3_prod_f + HALF_PF;
    assign w_term2 = $signed(w_sum_f[PF_W-1:FRAC_W]);
    assign n4_nv   = NV_W'(r3_term1) + NV_W'(w_term2);

    // ------------------------------------------------------------------
    // stage 5: clamp to +-velocity_limit
    // ------------------------------------------------------------------
    logic signed [NV_W-1:0]   w_vmax_pos;
    logic signed [NV_W-1:0]   w_vmax_neg;
    logic signed [NV_W-1:0]   w_nv_clamp;
    logic signed [WORD_W-1:0] r5_vel, n5_vel;
    logic signed [WORD_W-1:0] r5_pos;

    always_comb begin
        w_vmax_pos = $signed({{(NV_W-VLIM_W){1'b0}}, r_vlimit});
        w_vmax_neg = -w_vmax_pos;
        if (r4_nv < w_vmax_neg) begin
            w_nv_clamp = w_vmax_neg;
        end else if (r4_nv > w_vmax_pos) begin
            w_nv_clamp = w_vmax_pos;
        end else begin
            w_nv_clamp = r4_nv;
        end
        n5_vel = w_nv_clamp[WORD_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 6: move the position
    // ------------------------------------------------------------------
    logic signed [NP_W-1:0]   r6_np, n6_np;
    logic signed [WORD_W-1:0] r6_vel;

    assign n6_np = NP_W'(r5_pos) + NP_W'(r5_vel);

    // ------------------------------------------------------------------
    // stage 7: bound check and reflection, output register
    // lower bound wins when the bounds are crossed
    // ------------------------------------------------------------------
    logic signed [NP_W-1:0]   w_lb, w_ub;
    logic signed [NP_W-1:0]   w_half;
    logic                     n7_hit;
    logic signed [WORD_W-1:0] n7_vel, n7_pos;
    logic                     r7_hit;
    logic signed [WORD_W-1:0] r7_vel, r7_pos;

    always_comb begin
        w_lb   = NP_W'(r_lower);
        w_ub   = NP_W'(r_upper);
        w_half = (NP_W'(0) - NP_W'(r6_vel)) >>> 1;    // floor(-v / 2)
        n7_hit = 1'b0;
        n7_pos = r6_np[WORD_W-1:0];
        if (r6_np < w_lb) begin
            n7_hit = 1'b1;
            n7_pos = r_lower;
        end else if (r6_np > w_ub) begin
            n7_hit = 1'b1;
            n7_pos = r_upper;
        end
        n7_vel = n7_hit ? w_half[WORD_W-1:0] : r6_vel;
    end

    // payload registers, loaded when their stage advances
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_prod_w <= n1_prod_w;
            r1_prod_a <= n1_prod_a;
            r1_diff   <= n1_diff;
            r1_pos    <= w_p_in;
        end
        if (w_rdy[2]) begin
            r2_term1  <= n2_term1;
            r2_factor <= n2_factor;
            r2_diff   <= r1_diff;
            r2_pos    <= r1_pos;
        end
        if (w_rdy[3]) begin
            r3_prod_f <= n3_prod_f;
            r3_term1  <= r2_term1;
            r3_pos    <= r2_pos;
        end
        if (w_rdy[4]) begin
            r4_nv     <= n4_nv;
            r4_pos    <= r3_pos;
        end
        if (w_rdy[5]) begin
            r5_vel    <= n5_vel;
            r5_pos    <= r4_pos;
        end
        if (w_rdy[6]) begin
            r6_np     <= n6_np;
            r6_vel    <= r5_vel;
        end
        if (w_rdy[7]) begin
            r7_hit    <= n7_hit;
            r7_vel    <= n7_vel;
            r7_pos    <= n7_pos;
        end
    end

    assign m_axis_tvalid = r_vld[STAGES];
    assign m_axis_tdata  = {r7_pos, r7_vel};
    assign m_axis_tuser  = r7_hit;

`ifndef SYNTHESIS
    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // an accepted word lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[1])
        else $error("accepted word lost at pipe entry");

    // a blocked mid stage keeps its word
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] && !w_rdy[6] |=> r_vld[6] && $stable(r6_np) && $stable(r6_vel))
        else $error("stage 6 word changed while stalled");

    // an empty pipe takes input and shows no output
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == 0 |-> s_axis_tready && !m_axis_tvalid)
        else $error("empty pipe not ready");
`endif

endmodule : swarm_particle_coordinate_update

`default_nettype wire

// ===== sim/swarm_particle_coordinate_update_tb.sv =====
// Self-checking stream testbench for the swarm particle coordinate update block.
`timescale 1ns / 100ps

module swarm_particle_coordinate_update_tb;
    import spcu_pkg::*;

    // Run length guard, far above the slowest legal run
    localparam int     CYCLE_LIMIT = 200_000;
    localparam int     ONE         = 1 << FRAC_W;            // 1.0 in Q15.16
    localparam longint HALF_FRAC   = longint'(1) <<< (FRAC_W - 1);
    localparam longint HALF_RAND   = longint'(1) <<< (RAND_W - 1);

    // Input word, packed so that velocity sits in the low bits of tdata
    typedef struct packed {
        logic [RAND_W-1:0] frac;
        logic [WORD_W-1:0] exemplar;
        logic [WORD_W-1:0] position;
        logic [WORD_W-1:0] velocity;
    } coord_in_t;

    // Result word: {tuser, tdata}
    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] vel;
    } coord_out_t;

    // Register file shadow
    typedef struct packed {
        logic [COEF_W-1:0] inertia;
        logic [COEF_W-1:0] accel;
        logic [VLIM_W-1:0] vlimit;
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] upper;
    } coef_t;

    // DUT ports; every input has a known value from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [WORD_W-1:0]     i_cfg_data    = '0;

    // Predictor state and bookkeeping
    coef_t       coef;
    coord_out_t  pending_results[$];
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    logic        sink_hold     = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned coords_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned settings_used = 0;

    swarm_particle_coordinate_update DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one new velocity/position per coordinate word.
    // v' = w*v + round(c*r)*(e-p), each product rounded half up, then the
    // clamp to +-vlimit, the move, and the bound test (lower first, so a
    // position below a crossed lower bound lands on lower). A clamped position
    // reflects the velocity as floor(-v'/2).
    // ------------------------------------------------------------------
    function automatic coord_out_t update_coordinate(coord_in_t c);
        coord_out_t res;
        longint     v, p, e, lo, hi, vmax, factor, nv, np;
        v      = longint'($signed(c.velocity));
        p      = longint'($signed(c.position));
        e      = longint'($signed(c.exemplar));
        lo     = longint'($signed(coef.lower));
        hi     = longint'($signed(coef.upper));
        vmax   = longint'(coef.vlimit);
        factor = (longint'(coef.accel) * longint'(c.frac) + HALF_RAND) >>> RAND_W;
        nv     = ((longint'(coef.inertia) * v + HALF_FRAC) >>> FRAC_W)
               + ((factor * (e - p) + HALF_FRAC) >>> FRAC_W);
        if (nv < -vmax) begin
            nv = -vmax;
        end else if (nv > vmax) begin
            nv = vmax;
        end
        np      = p + nv;
        res.hit = 1'b0;
        if (np < lo) begin
            np      = lo;
            res.hit = 1'b1;
        end else if (np > hi) begin
            np      = hi;
            res.hit = 1'b1;
        end
        if (res.hit) begin
            nv = (-nv) >>> 1;
        end
        res.vel = nv[WORD_W-1:0];
        res.pos = np[WORD_W-1:0];
        return res;
    endfunction

    // Uniform pick in [lo, hi]
    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        if (hi <= lo) begin
            return lo;
        end
        span = $unsigned(hi - lo) + 64'd1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic coord_in_t make_coord(logic [WORD_W-1:0] v, logic [WORD_W-1:0] p,
                                             logic [WORD_W-1:0] e, logic [RAND_W-1:0] r);
        coord_in_t c;
        c.velocity = v;
        c.position = p;
        c.exemplar = e;
        c.frac     = r;
        return c;
    endfunction

    // Mostly coordinates a swarm would really produce: position and exemplar
    // inside the box, velocity inside the limit. Some sit close to a bound,
    // some are raw noise over the whole word.
    function automatic coord_in_t random_coord();
        coord_in_t c;
        longint    lo, hi, vm, tmp;
        int        pick;
        lo   = longint'($signed(coef.lower));
        hi   = longint'($signed(coef.upper));
        vm   = longint'(coef.vlimit);
        pick = $urandom_range(99);
        if (hi < lo) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        c.frac = RAND_W'($urandom);
        if (pick < 10) begin
            c.velocity = $urandom;
            c.position = $urandom;
            c.exemplar = $urandom;
        end else if (pick < 25) begin
            tmp        = ($urandom_range(1) == 0) ? lo : hi;
            c.position = WORD_W'(tmp + rand_between(-1024, 1024));
            c.velocity = WORD_W'(rand_between(-vm, vm));
            c.exemplar = WORD_W'(rand_between(lo, hi));
        end else begin
            c.position = WORD_W'(rand_between(lo, hi));
            c.velocity = WORD_W'(rand_between(-vm, vm));
            c.exemplar = WORD_W'(rand_between(lo, hi));
        end
        return c;
    endfunction

    // Coefficients mostly near the usual constriction values, sometimes anywhere
    function automatic coef_t random_coefs();
        coef_t  s;
        longint a, b;
        s.inertia = ($urandom_range(3) == 0) ? COEF_W'($urandom)
                                             : COEF_W'($urandom_range(30000, 70000));
        s.accel   = ($urandom_range(3) == 0) ? COEF_W'($urandom)
                                             : COEF_W'($urandom_range(60000, 140000));
        s.vlimit  = ($urandom_range(3) == 0) ? VLIM_W'($urandom)
                                             : VLIM_W'($urandom_range(ONE, 400 * ONE));
        if ($urandom_range(9) == 0) begin
            // full-range bounds, crossed about half the time
            s.lower = $urandom;
            s.upper = $urandom;
        end else begin
            a       = rand_between(-1000 * ONE, 1000 * ONE);
            b       = rand_between(-1000 * ONE, 1000 * ONE);
            s.lower = WORD_W'((a < b) ? a : b);
            s.upper = WORD_W'((a < b) ? b : a);
        end
        return s;
    endfunction

    task automatic note_error(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: per-cycle random ready, forced low during a hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Long output stall, counted here while the sender keeps pushing
    task automatic hold_output(input int unsigned cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold <= 1'b0;
    endtask

    // Result checker: each accepted word against the oldest prediction
    always @(posedge i_clk) begin : result_check
        coord_out_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            results_seen++;
            if (pending_results.size() == 0) begin
                note_error("unexpected result word", '0, got.vel);
            end else begin
                want = pending_results.pop_front();
                if (got.vel !== want.vel) note_error("velocity_out", want.vel, got.vel);
                if (got.pos !== want.pos) note_error("position_out", want.pos, got.pos);
                if (got.hit !== want.hit) note_error("bound_hit", WORD_W'(want.hit),
                                                     WORD_W'(got.hit));
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, with an optional idle gap first. tvalid stays high
    // across back-to-back words; the prediction is queued on acceptance.
    task automatic send_coord(input coord_in_t c);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(update_coordinate(c));
        coords_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One register write; the shadow follows the same field masking
    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INERTIA: coef.inertia = data[COEF_W-1:0];
            CFG_ACCEL:   coef.accel   = data[COEF_W-1:0];
            CFG_VLIMIT:  coef.vlimit  = data[VLIM_W-1:0];
            CFG_LOWER:   coef.lower   = data;
            CFG_UPPER:   coef.upper   = data;
            default:     ;
        endcase
    endtask

    task automatic cfg_done();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all five registers; unused high bits carry junk that must be dropped
    task automatic apply_settings(input logic [COEF_W-1:0] inertia,
                                  input logic [COEF_W-1:0] accel,
                                  input logic [VLIM_W-1:0] vlimit,
                                  input logic [WORD_W-1:0] lower,
                                  input logic [WORD_W-1:0] upper);
        wait_drained();
        cfg_word(CFG_INERTIA, {(WORD_W - COEF_W)'($urandom), inertia});
        cfg_word(CFG_ACCEL,   {(WORD_W - COEF_W)'($urandom), accel});
        cfg_word(CFG_VLIMIT,  {(WORD_W - VLIM_W)'($urandom), vlimit});
        cfg_word(CFG_LOWER,   lower);
        cfg_word(CFG_UPPER,   upper);
        cfg_done();
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients: zero word, saturating velocities, both bounds,
    // far-outside positions and the rounding of tiny products
    task automatic test_reset_defaults();
        send_coord(make_coord('0, '0, '0, '0));
        send_coord(make_coord(32'h7FFF_FFFF, '0, '0, 16'h0000));
        send_coord(make_coord(32'h8000_0000, '0, '0, 16'hFFFF));
        send_coord(make_coord(32'(100 * ONE), RST_UPPER, RST_UPPER, 16'h8000));
        send_coord(make_coord(32'(-100 * ONE), RST_LOWER, RST_LOWER, 16'h8000));
        send_coord(make_coord('0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
        send_coord(make_coord('0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
        send_coord(make_coord(32'(ONE / 2 + 1), 32'(10 * ONE), 32'(-10 * ONE), 16'h0001));
        send_coord(make_coord(32'h0000_0001, '0, 32'h0000_0001, 16'h0001));
    endtask

    // Coefficients and limit at their top values with the widest bounds, then every register at zero
    task automatic test_register_extremes();
        apply_settings('1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_coord(make_coord(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
        send_coord(make_coord(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
        send_coord(make_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000));
        send_coord(make_coord(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000));
        // zero limit and a box collapsed to one point
        apply_settings('0, '0, '0, '0, '0);
        send_coord(make_coord(32'(5 * ONE), '0, 32'(9 * ONE), 16'hFFFF));
        send_coord(make_coord('0, 32'h0000_0001, '0, 16'h1234));
        send_coord(make_coord('0, 32'hFFFF_FFFF, '0, 16'h1234));
        send_coord(make_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    endtask

    // lower > upper: the lower test wins, upper only if not below lower
    task automatic test_crossed_bounds();
        apply_settings(COEF_W'(ONE), '0, '1, 32'(100 * ONE), 32'(-100 * ONE));
        send_coord(make_coord('0, '0, '0, 16'h4000));
        send_coord(make_coord('0, 32'(200 * ONE), '0, 16'h4000));
    endtask

    // Unit inertia, no pull: odd velocities show floor in the halving
    task automatic test_reflection_rounding();
        apply_settings(COEF_W'(ONE), '0, VLIM_W'(1000 * ONE), RST_LOWER, RST_UPPER);
        send_coord(make_coord(32'h0000_0003, RST_UPPER, RST_UPPER, 16'hFFFF));
        send_coord(make_coord(32'hFFFF_FFFD, RST_LOWER, RST_LOWER, 16'hFFFF));
    endtask

    // Writes to indexes past the register list must change nothing
    task automatic test_unused_index();
        wait_drained();
        for (int k = int'(CFG_UPPER) + 1; k < (1 << CFG_IDX_W); k++) begin
            cfg_word(CFG_IDX_W'(k), $urandom);
        end
        cfg_done();
        send_coord(make_coord(32'(50 * ONE), 32'(480 * ONE), 32'(-300 * ONE), 16'hA5A5));
    endtask

    // Random words over several random settings under one idle profile.
    // Now and then the sender waits for the pipe to empty.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_settings, input int per_setting);
        coef_t s;
        src_idle_pct   = src_pct;
        sink_idle_pct <= sink_pct;
        for (int k = 0; k < n_settings; k++) begin
            s = random_coefs();
            apply_settings(s.inertia, s.accel, s.vlimit, s.lower, s.upper);
            for (int n = 0; n < per_setting; n++) begin
                send_coord(random_coord());
                if ($urandom_range(99) == 0) wait_drained();
            end
        end
    endtask

    // Output held off for a long stretch while words keep coming, so the
    // pipe fills and input ready drops; then a full drain before moving on
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_idle_pct <= 0;
        fork
            hold_output(300);
        join_none
        for (int n = 0; n < 60; n++) begin
            send_coord(random_coord());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        coef = {RST_INERTIA, RST_ACCEL, RST_VLIMIT, RST_LOWER, RST_UPPER};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_crossed_bounds();
        test_reflection_rounding();
        test_unused_index();

        test_random_traffic(16, 54, 3, 140);
        test_random_traffic(54, 16, 3, 140);
        test_backpressure();
        test_random_traffic(0, 0, 3, 140);

        // all accepted; let any stray word surface past the pipeline depth
        wait_drained();
        repeat (STAGES + 8) @(posedge i_clk);

        $display("Sent %0d coordinate words under %0d register settings, %0d results checked.",
                 coords_sent, settings_used, results_seen);
        $display("Covered field extremes, collapsed and crossed bounds, reflection, "
                 , "unused indexes and a long output stall.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d errors", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== swarm_particle_coordinate_update.f =====
rtl/core/spcu_pkg.sv
rtl/core/swarm_particle_coordinate_update.sv
sim/swarm_particle_coordinate_update_tb.sv
